// File: hdl/lzw_variable_width_encoder_assert.svh
// assertion macros used by the encoder control module
`ifndef LZW_VARIABLE_WIDTH_ENCODER_ASSERT_SVH
`define LZW_VARIABLE_WIDTH_ENCODER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define LVWE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lvwe assertion failed");

// condition must hold in the cycle after the trigger
`define LVWE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lvwe assertion failed");

`endif

// File: hdl/lvwe_pkg.sv
`default_nettype none
package lvwe_pkg;

    localparam int DICT_SIZE  = 4096;
    localparam int CODE_BITS  = 12;
    localparam int HASH_SLOTS = 8192;

    localparam int DICT_AW    = $clog2(DICT_SIZE);
    localparam int NC_W       = $clog2(DICT_SIZE + 1);
    localparam int HASH_BITS  = $clog2(HASH_SLOTS);
    localparam int KEY_W      = DICT_AW + 8;
    localparam int EPOCH_BITS = 8;
    localparam int CW_W       = 4;
    localparam int ALPHA_W    = 9;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(256);
    localparam logic [31:0]        HASH_MULT   = 32'h9E37_79B1;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] tag;
        logic [DICT_AW-1:0]    code;
    } lvwe_slot_t;

    typedef struct packed {
        logic accept;
        logic start_msg;
        logic hash;
        logic slot_rd;
        logic dict_rd;
        logic probe_next;
        logic hit;
        logic miss;
        logic sym_take;
        logic err;
        logic flush;
        logic end_msg;
        logic clr_step;
    } lvwe_cmd_t;

    typedef struct packed {
        logic aborted;
        logic match_valid;
        logic sym_ok;
        logic slot_empty;
        logic key_eq;
        logic probe_last;
        logic eom;
        logic out_free;
        logic clr_last;
        logic epoch_last;
    } lvwe_sts_t;

    // number of significant bits, at least one
    function automatic logic [CW_W-1:0] bit_count(input logic [NC_W-1:0] v);
        logic [CW_W-1:0] n;
        n = CW_W'(1);
        for (int i = 0; i < NC_W; i++) begin
            if (v[i]) n = CW_W'(i + 1);
        end
        return n;
    endfunction

    // multiplicative hash, low bits only
    function automatic logic [HASH_BITS-1:0] hash_of(input logic [KEY_W-1:0] key);
        logic [HASH_BITS-1:0] k;
        logic [HASH_BITS-1:0] m;
        k = HASH_BITS'(key);
        m = HASH_MULT[HASH_BITS-1:0];
        return HASH_BITS'(k * m);
    endfunction

endpackage
`default_nettype wire

// File: hdl/lzw_variable_width_encoder.sv
`default_nettype none
// lzw encoder with variable code width. kind 0 transactions load the symbol
// table (byte to starting code) and give no result. kind 1 transactions
// carry message bytes; each one takes a dictionary probe through a hashed
// slot table: a slot read, then a dictionary read, then a compare, with the
// next slot read again for each occupied slot that is skipped on a
// collision. when the match ends a code is sent, and the final byte adds a
// flush. the first byte of a message needs no probe. a code waits while the
// result register is still full. the block takes one byte at a time: no new
// transaction is taken on the input side until the last one is done.
// up to two result transactions per byte; code_width gives the bits to
// send. a byte outside the alphabet gives one error result and the rest
// of the message is dropped. the hash slots are tagged with a message epoch,
// so the dictionary clears at message end for free; after reset and after
// every 255 messages a sweep clears the slot table, during which no
// transaction is taken on the input side (alphabet_size writes are).
module lzw_variable_width_encoder (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [lvwe_pkg::ALPHA_W-1:0]   cfg_wr_data,
    // input channel
    input  wire logic                           s_valid,
    output      logic                           s_ready,
    input  wire logic                           s_kind,
    input  wire logic [7:0]                     s_byte_value,
    input  wire logic [7:0]                     s_alphabet_position,
    input  wire logic                           s_end_of_message,
    // result channel
    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output      logic [lvwe_pkg::CODE_BITS-1:0] m_code,
    output      logic [lvwe_pkg::CW_W-1:0]      m_code_width,
    output      logic                           m_error,
    output      logic                           m_message_done,
    output      logic                           m_last_of_item
);
    import lvwe_pkg::*;

    // commands from the sequencer, status back from the datapath
    lvwe_cmd_t cmd;
    lvwe_sts_t sts;

    lvwe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // symbol table, dictionary, slot table and the result register
    lvwe_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_kind              (s_kind),
        .s_byte_value        (s_byte_value),
        .s_alphabet_position (s_alphabet_position),
        .s_end_of_message    (s_end_of_message),
        .m_ready             (m_ready),
        .m_valid             (m_valid),
        .m_code              (m_code),
        .m_code_width        (m_code_width),
        .m_error             (m_error),
        .m_message_done      (m_message_done),
        .m_last_of_item      (m_last_of_item),
        .cmd                 (cmd),
        .sts                 (sts)
    );

endmodule
`default_nettype wire

// File: hdl/lvwe_datapath.sv
`default_nettype none
module lvwe_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lvwe_pkg::ALPHA_W-1:0]    cfg_wr_data,
    input  logic                            s_kind,
    input  logic [7:0]                      s_byte_value,
    input  logic [7:0]                      s_alphabet_position,
    input  logic                            s_end_of_message,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [lvwe_pkg::CODE_BITS-1:0]  m_code,
    output logic [lvwe_pkg::CW_W-1:0]       m_code_width,
    output logic                            m_error,
    output logic                            m_message_done,
    output logic                            m_last_of_item,
    input  lvwe_pkg::lvwe_cmd_t             cmd,
    output lvwe_pkg::lvwe_sts_t             sts
);
    import lvwe_pkg::*;

    logic [7:0]            sym_mem [256];
    logic [255:0]          sym_vld_reg;
    logic [7:0]            sym_code_reg;
    logic                  sym_hit_reg;
    logic [KEY_W-1:0]      dict_mem [DICT_SIZE];
    logic [KEY_W-1:0]      dict_q_reg;
    lvwe_slot_t            hash_mem [HASH_SLOTS];
    lvwe_slot_t            slot_reg;

    logic [ALPHA_W-1:0]    alpha_reg;
    logic [7:0]            byte_reg;
    logic                  eom_reg;
    logic [DICT_AW-1:0]    match_reg;
    logic                  match_vld_reg;
    logic                  first_reg;
    logic                  abort_reg;
    logic [NC_W-1:0]       next_code_reg;
    logic [EPOCH_BITS-1:0] epoch_reg;
    logic [HASH_BITS-1:0]  probe_addr_reg;
    logic [HASH_BITS-1:0]  probe_cnt_reg;
    logic [HASH_BITS-1:0]  clr_cnt_reg;
    logic                  m_valid_reg;

    logic [KEY_W-1:0]      key;
    logic                  slot_empty;
    logic                  ins_ok;
    logic                  sym_ok;
    logic [NC_W-1:0]       nc_m1;
    logic [CW_W-1:0]       emit_w;
    logic                  emit;

    assign key        = {match_reg, byte_reg};
    assign slot_empty = slot_reg.tag != epoch_reg;
    assign ins_ok     = slot_empty && (next_code_reg < NC_W'(DICT_SIZE));
    assign sym_ok     = sym_hit_reg && (ALPHA_W'(sym_code_reg) < alpha_reg);
    assign nc_m1      = (next_code_reg == '0) ? '0 : next_code_reg - NC_W'(1);
    assign emit_w     = first_reg ? bit_count(nc_m1) : bit_count(next_code_reg);
    assign emit       = cmd.miss || cmd.err || cmd.flush;

    // symbol table
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            if (!s_kind) sym_mem[s_byte_value] <= s_alphabet_position;
            sym_code_reg <= sym_mem[s_byte_value];
            sym_hit_reg  <= sym_vld_reg[s_byte_value];
            byte_reg     <= s_byte_value;
            eom_reg      <= s_end_of_message;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_vld_reg <= '0;
        end else if (cmd.accept && !s_kind) begin
            sym_vld_reg[s_byte_value] <= 1'b1;
        end
    end

    // hash slots, tagged with the message epoch
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            hash_mem[clr_cnt_reg] <= '0;
        end else if (cmd.miss && ins_ok) begin
            hash_mem[probe_addr_reg] <= '{tag: epoch_reg, code: next_code_reg[DICT_AW-1:0]};
        end
        if (cmd.slot_rd) slot_reg <= hash_mem[probe_addr_reg];
    end

    // dictionary entries
    always_ff @(posedge aclk) begin
        if (cmd.miss && ins_ok) dict_mem[next_code_reg[DICT_AW-1:0]] <= key;
        if (cmd.dict_rd) dict_q_reg <= dict_mem[slot_reg.code];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg      <= ALPHA_RESET;
            match_reg      <= '0;
            match_vld_reg  <= 1'b0;
            first_reg      <= 1'b0;
            abort_reg      <= 1'b0;
            next_code_reg  <= NC_W'(ALPHA_RESET);
            epoch_reg      <= EPOCH_BITS'(1);
            probe_addr_reg <= '0;
            probe_cnt_reg  <= '0;
            clr_cnt_reg    <= '0;
        end else begin
            if (cfg_wr_en) alpha_reg <= cfg_wr_data;
            if (cmd.hash) begin
                probe_addr_reg <= hash_of(key);
                probe_cnt_reg  <= '0;
            end
            if (cmd.probe_next) begin
                probe_addr_reg <= probe_addr_reg + HASH_BITS'(1);
                probe_cnt_reg  <= probe_cnt_reg + HASH_BITS'(1);
            end
            if (cmd.start_msg) next_code_reg <= NC_W'(alpha_reg);
            if (cmd.hit) match_reg <= slot_reg.code;
            if (cmd.miss) begin
                first_reg     <= 1'b1;
                match_vld_reg <= 1'b0;
                if (ins_ok) next_code_reg <= next_code_reg + NC_W'(1);
            end
            if (cmd.sym_take) begin
                match_reg     <= DICT_AW'(sym_code_reg);
                match_vld_reg <= 1'b1;
            end
            if (cmd.err && !eom_reg) abort_reg <= 1'b1;
            if (cmd.end_msg) begin
                match_reg     <= '0;
                match_vld_reg <= 1'b0;
                first_reg     <= 1'b0;
                abort_reg     <= 1'b0;
                next_code_reg <= NC_W'(alpha_reg);
                epoch_reg     <= epoch_reg + EPOCH_BITS'(1);
            end
            if (cmd.clr_step) begin
                if (sts.clr_last) begin
                    clr_cnt_reg <= '0;
                    epoch_reg   <= EPOCH_BITS'(1);
                end else begin
                    clr_cnt_reg <= clr_cnt_reg + HASH_BITS'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_code         <= cmd.err ? '0 : CODE_BITS'(match_reg);
            m_code_width   <= cmd.err ? '0 : emit_w;
            m_error        <= cmd.err;
            m_message_done <= cmd.err || cmd.flush;
            m_last_of_item <= cmd.miss ? (sym_ok && !eom_reg) : 1'b1;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        sts             = '0;
        sts.aborted     = abort_reg;
        sts.match_valid = match_vld_reg;
        sts.sym_ok      = sym_ok;
        sts.slot_empty  = slot_empty;
        sts.key_eq      = dict_q_reg == key;
        sts.probe_last  = probe_cnt_reg == HASH_BITS'(HASH_SLOTS - 1);
        sts.eom         = eom_reg;
        sts.out_free    = !m_valid_reg || m_ready;
        sts.clr_last    = clr_cnt_reg == HASH_BITS'(HASH_SLOTS - 1);
        sts.epoch_last  = epoch_reg == '1;
    end

endmodule
`default_nettype wire

// File: hdl/lvwe_ctrl.sv
`default_nettype none
`include "lzw_variable_width_encoder_assert.svh"
module lvwe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_kind,
    output logic                s_ready,
    output lvwe_pkg::lvwe_cmd_t cmd,
    input  lvwe_pkg::lvwe_sts_t sts
);
    import lvwe_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_SLOT  = 4'd3;
    localparam logic [3:0] S_CHK1  = 4'd4;
    localparam logic [3:0] S_CHK2  = 4'd5;
    localparam logic [3:0] S_MISS  = 4'd6;
    localparam logic [3:0] S_START = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] after_end;

    // wrap of the epoch forces a sweep of the hash slots
    assign after_end = sts.epoch_last ? S_CLEAR : S_IDLE;

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && s_kind) state_next = S_DISP;
            end
            S_DISP: begin
                if (sts.aborted) begin
                    if (sts.eom) begin
                        cmd.end_msg = 1'b1;
                        state_next  = after_end;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else if (!sts.match_valid) begin
                    cmd.start_msg = 1'b1;
                    state_next    = S_START;
                end else begin
                    cmd.hash   = 1'b1;
                    state_next = S_SLOT;
                end
            end
            S_SLOT: begin
                cmd.slot_rd = 1'b1;
                state_next  = S_CHK1;
            end
            S_CHK1: begin
                if (sts.slot_empty) begin
                    state_next = S_MISS;
                end else begin
                    cmd.dict_rd = 1'b1;
                    state_next  = S_CHK2;
                end
            end
            S_CHK2: begin
                if (sts.key_eq) begin
                    cmd.hit    = 1'b1;
                    state_next = sts.eom ? S_FLUSH : S_IDLE;
                end else if (sts.probe_last) begin
                    state_next = S_MISS;
                end else begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_SLOT;
                end
            end
            S_MISS: begin
                if (sts.out_free) begin
                    cmd.miss   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (!sts.sym_ok) begin
                    if (sts.out_free) begin
                        cmd.err = 1'b1;
                        if (sts.eom) begin
                            cmd.end_msg = 1'b1;
                            state_next  = after_end;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                end else begin
                    cmd.sym_take = 1'b1;
                    state_next   = sts.eom ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (sts.out_free) begin
                    cmd.flush   = 1'b1;
                    cmd.end_msg = 1'b1;
                    state_next  = after_end;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    `LVWE_ASSERT_IMPL(a_one_result, aclk, aresetn, 1'b1, ($onehot0({cmd.miss, cmd.err, cmd.flush})))
    `LVWE_ASSERT_IMPL(a_emit_free, aclk, aresetn, (cmd.miss || cmd.err || cmd.flush), sts.out_free)
    `LVWE_ASSERT_NEXT(a_end_idle, aclk, aresetn, cmd.end_msg, (state_reg == S_IDLE || state_reg == S_CLEAR))
    `LVWE_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, cmd.accept, (state_reg == S_IDLE))

endmodule
`default_nettype wire
